@@ hw/rtl/led_halfbridge_duty_router_macros.svh @@
// ----------------------------------------------------------------------------
// LED half-bridge duty router: assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_HALFBRIDGE_DUTY_ROUTER_MACROS_SVH
`define LED_HALFBRIDGE_DUTY_ROUTER_MACROS_SVH

// Same-cycle implication.
`define LHDR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LHDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lhdr_pkg.sv @@
// ----------------------------------------------------------------------------
// lhdr_pkg
// Shared constants, codes and types of the LED half-bridge duty router.
// ----------------------------------------------------------------------------
package lhdr_pkg;

  localparam int DUTY_BITS_DEF = 13;
  localparam int LVL_BITS      = 8;
  localparam int NUM_OUT       = 4;
  localparam int NUM_CH        = 8;

  // APB
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_ROLE1 = 3'd1;
  localparam logic [2:0] REG_ROLE2 = 3'd2;
  localparam logic [2:0] REG_ROLE3 = 3'd3;
  localparam logic [2:0] REG_ROLE4 = 3'd4;
  localparam logic [2:0] REG_FADE  = 3'd5;

  // driver modes
  localparam logic [1:0] MODE_RGB   = 2'd1;
  localparam logic [1:0] MODE_WHITE = 2'd2;

  // output roles
  localparam logic [2:0] ROLE_PLUS  = 3'd0;
  localparam logic [2:0] ROLE_MINUS = 3'd1;
  localparam logic [2:0] ROLE_RED   = 3'd2;
  localparam logic [2:0] ROLE_GREEN = 3'd3;
  localparam logic [2:0] ROLE_BLUE  = 3'd4;
  localparam logic [2:0] ROLE_WHITE = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MODE     = 3'd1;
  localparam logic [2:0] ST_POLARITY = 3'd2;
  localparam logic [2:0] ST_COLORS   = 3'd3;
  localparam logic [2:0] ST_PAIR     = 3'd4;

  // reset values
  localparam logic [1:0]  MODE_RST  = 2'd0;
  localparam logic [2:0]  ROLE1_RST = ROLE_PLUS;
  localparam logic [2:0]  ROLE2_RST = ROLE_RED;
  localparam logic [2:0]  ROLE3_RST = ROLE_GREEN;
  localparam logic [2:0]  ROLE4_RST = ROLE_BLUE;
  localparam logic [15:0] FADE_RST  = 16'd2000;

  // level vector slots between scaler and router
  localparam int LV_NUM   = 5;
  localparam int LV_RED   = 0;
  localparam int LV_GREEN = 1;
  localparam int LV_BLUE  = 2;
  localparam int LV_A     = 3;
  localparam int LV_B     = 4;

  // per-channel duty source
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_FULL,
    SRC_RED,
    SRC_GREEN,
    SRC_BLUE,
    SRC_LVA,
    SRC_LVB
  } src_t;

  // routing decision, derived from configuration only
  typedef struct packed {
    src_t [NUM_CH-1:0] src;
    logic [NUM_CH-1:0] wmask;
    logic [NUM_CH-1:0] fmask;
    logic [2:0]        status;
  } plan_t;

endpackage

@@ hw/rtl/led_halfbridge_duty_router.sv @@
// ----------------------------------------------------------------------------
// led_halfbridge_duty_router
// Maps one light command onto eight half-bridge channel duties plus masks.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid/in_ready     light_on, red, green, blue,
//                                              level_a, level_b
//   out_      output     out_valid/out_ready   duty_ch0..7, write_mask,
//                                              fade_mask, status
//   APB       config     psel/penable/pready   mode, roles 1..4, fade time
//
// Throughput: one transaction per cycle while out_ready is high.
// Pipeline: four register stages (widen, multiply, divide-by-full-scale,
//   route/output register).
// Stalls: out_ready low freezes the output register; stages behind it fill
//   up bubble by bubble, then in_ready drops. Nothing is dropped or repeated.
// Reset: rst_n (sync, active low) clears all stage valids and restores the
//   register defaults (mode invalid, roles plus/red/green/blue, fade 2000 ms).
// ----------------------------------------------------------------------------
module led_halfbridge_duty_router #(
  parameter int DUTY_BITS = lhdr_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_light_on,
  input  logic [lhdr_pkg::LVL_BITS-1:0]   in_red,
  input  logic [lhdr_pkg::LVL_BITS-1:0]   in_green,
  input  logic [lhdr_pkg::LVL_BITS-1:0]   in_blue,
  input  logic [lhdr_pkg::LVL_BITS-1:0]   in_level_a,
  input  logic [lhdr_pkg::LVL_BITS-1:0]   in_level_b,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [DUTY_BITS-1:0]            out_duty_ch0,
  output logic [DUTY_BITS-1:0]            out_duty_ch1,
  output logic [DUTY_BITS-1:0]            out_duty_ch2,
  output logic [DUTY_BITS-1:0]            out_duty_ch3,
  output logic [DUTY_BITS-1:0]            out_duty_ch4,
  output logic [DUTY_BITS-1:0]            out_duty_ch5,
  output logic [DUTY_BITS-1:0]            out_duty_ch6,
  output logic [DUTY_BITS-1:0]            out_duty_ch7,
  output logic [lhdr_pkg::NUM_CH-1:0]     out_write_mask,
  output logic [lhdr_pkg::NUM_CH-1:0]     out_fade_mask,
  output logic [2:0]                      out_status,
  // APB register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lhdr_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lhdr_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lhdr_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);

  // Routing plan depends only on the registers, so it is decoded and registered
  // apart; the pipe just carries the levels. The user must change registers only while idle; not enforced here.
  lhdr_pkg::plan_t                                plan;
  logic                                           sc_valid;
  logic                                           sc_ready;
  logic [lhdr_pkg::LV_NUM-1:0][DUTY_BITS-1:0]     levels;
  logic [lhdr_pkg::NUM_CH-1:0][DUTY_BITS-1:0]     duty;

  lhdr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .plan    (plan)
  );

  // Stages 1-3: widen (v << (DUTY_BITS-8) | ones), color x brightness,
  // exact divide by 2^DUTY_BITS - 1 with the shift-add identity.
  lhdr_scale #(
    .DUTY_BITS (DUTY_BITS)
  ) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_light_on (in_light_on),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .in_level_a  (in_level_a),
    .in_level_b  (in_level_b),
    .dn_valid    (sc_valid),
    .dn_ready    (sc_ready),
    .levels      (levels)
  );

  // Stage 4: channel select and output register.
  lhdr_route #(
    .DUTY_BITS (DUTY_BITS)
  ) u_route (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (sc_valid),
    .up_ready   (sc_ready),
    .levels     (levels),
    .plan       (plan),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .duty       (duty),
    .write_mask (out_write_mask),
    .fade_mask  (out_fade_mask),
    .status     (out_status)
  );

  assign out_duty_ch0 = duty[0];
  assign out_duty_ch1 = duty[1];
  assign out_duty_ch2 = duty[2];
  assign out_duty_ch3 = duty[3];
  assign out_duty_ch4 = duty[4];
  assign out_duty_ch5 = duty[5];
  assign out_duty_ch6 = duty[6];
  assign out_duty_ch7 = duty[7];

endmodule

@@ hw/rtl/lhdr_cfg.sv @@
// ----------------------------------------------------------------------------
// lhdr_cfg
// APB register file and routing plan decode (registered).
// ----------------------------------------------------------------------------
module lhdr_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lhdr_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lhdr_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lhdr_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  output lhdr_pkg::plan_t                 plan
);

  logic [1:0]  mode_r;
  logic [2:0]  role_r [lhdr_pkg::NUM_OUT];
  logic [15:0] fade_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  lhdr_pkg::plan_t plan_nxt;
  lhdr_pkg::plan_t plan_r;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lhdr_pkg::MODE_RST;
      role_r[0] <= lhdr_pkg::ROLE1_RST;
      role_r[1] <= lhdr_pkg::ROLE2_RST;
      role_r[2] <= lhdr_pkg::ROLE3_RST;
      role_r[3] <= lhdr_pkg::ROLE4_RST;
      fade_r    <= lhdr_pkg::FADE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lhdr_pkg::REG_MODE:  mode_r    <= pwdata[1:0];
        lhdr_pkg::REG_ROLE1: role_r[0] <= pwdata[2:0];
        lhdr_pkg::REG_ROLE2: role_r[1] <= pwdata[2:0];
        lhdr_pkg::REG_ROLE3: role_r[2] <= pwdata[2:0];
        lhdr_pkg::REG_ROLE4: role_r[3] <= pwdata[2:0];
        lhdr_pkg::REG_FADE:  fade_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lhdr_pkg::REG_MODE:  prdata = {30'd0, mode_r};
      lhdr_pkg::REG_ROLE1: prdata = {29'd0, role_r[0]};
      lhdr_pkg::REG_ROLE2: prdata = {29'd0, role_r[1]};
      lhdr_pkg::REG_ROLE3: prdata = {29'd0, role_r[2]};
      lhdr_pkg::REG_ROLE4: prdata = {29'd0, role_r[3]};
      lhdr_pkg::REG_FADE:  prdata = {16'd0, fade_r};
      default:             prdata = '0;
    endcase
  end

  // plan decode
  always_comb begin
    logic [2:0]     npol;
    logic [2:0]     nr;
    logic [2:0]     ng;
    logic [2:0]     nb;
    logic [1:0]     pol;
    logic           plus;
    logic [2:0]     ra;
    logic [2:0]     rb;
    lhdr_pkg::src_t lv;
    lhdr_pkg::src_t v;
    npol     = '0;
    nr       = '0;
    ng       = '0;
    nb       = '0;
    pol      = '0;
    plus     = 1'b0;
    ra       = '0;
    rb       = '0;
    lv       = lhdr_pkg::SRC_LVA;
    v        = lhdr_pkg::SRC_BLUE;
    plan_nxt = '0;
    for (int i = 0; i < lhdr_pkg::NUM_CH; i++) begin
      plan_nxt.src[i] = lhdr_pkg::SRC_ZERO;
    end
    plan_nxt.status = lhdr_pkg::ST_OK;

    case (mode_r)
      lhdr_pkg::MODE_RGB: begin
        for (int i = 0; i < lhdr_pkg::NUM_OUT; i++) begin
          if (role_r[i] == lhdr_pkg::ROLE_PLUS || role_r[i] == lhdr_pkg::ROLE_MINUS) begin
            npol = npol + 3'd1;
            pol  = 2'(i);
          end
          if (role_r[i] == lhdr_pkg::ROLE_RED)   nr = nr + 3'd1;
          if (role_r[i] == lhdr_pkg::ROLE_GREEN) ng = ng + 3'd1;
          if (role_r[i] == lhdr_pkg::ROLE_BLUE)  nb = nb + 3'd1;
        end
        if (npol != 3'd1) begin
          plan_nxt.status = lhdr_pkg::ST_POLARITY;
        end else if (nr != 3'd1 || ng != 3'd1 || nb != 3'd1) begin
          plan_nxt.status = lhdr_pkg::ST_COLORS;
        end else begin
          plus = (role_r[pol] == lhdr_pkg::ROLE_PLUS);
          for (int i = 0; i < lhdr_pkg::NUM_OUT; i++) begin
            if (2'(i) == pol) begin
              plan_nxt.src[2*i]   = plus ? lhdr_pkg::SRC_ZERO : lhdr_pkg::SRC_FULL;
              plan_nxt.src[2*i+1] = plus ? lhdr_pkg::SRC_FULL : lhdr_pkg::SRC_ZERO;
            end else begin
              v = (role_r[i] == lhdr_pkg::ROLE_RED)   ? lhdr_pkg::SRC_RED :
                  (role_r[i] == lhdr_pkg::ROLE_GREEN) ? lhdr_pkg::SRC_GREEN :
                                                        lhdr_pkg::SRC_BLUE;
              plan_nxt.src[2*i]   = plus ? v : lhdr_pkg::SRC_ZERO;
              plan_nxt.src[2*i+1] = plus ? lhdr_pkg::SRC_ZERO : v;
              plan_nxt.fmask[2*i +: 2] = 2'b11;
            end
          end
          plan_nxt.wmask = '1;
        end
      end
      lhdr_pkg::MODE_WHITE: begin
        for (int p = 0; p < 2; p++) begin
          ra = role_r[2*p];
          rb = role_r[2*p+1];
          lv = (p == 1) ? lhdr_pkg::SRC_LVB : lhdr_pkg::SRC_LVA;
          if (ra == lhdr_pkg::ROLE_WHITE && rb == lhdr_pkg::ROLE_PLUS) begin
            plan_nxt.src[4*p]   = lv;
            plan_nxt.src[4*p+3] = lhdr_pkg::SRC_FULL;
            plan_nxt.wmask[4*p +: 4] = 4'hF;
            plan_nxt.fmask[4*p]      = 1'b1;
          end else if (ra == lhdr_pkg::ROLE_WHITE && rb == lhdr_pkg::ROLE_MINUS) begin
            plan_nxt.src[4*p+1] = lv;
            plan_nxt.src[4*p+2] = lhdr_pkg::SRC_FULL;
            plan_nxt.wmask[4*p +: 4] = 4'hF;
            plan_nxt.fmask[4*p+1]    = 1'b1;
          end else if (ra == lhdr_pkg::ROLE_PLUS && rb == lhdr_pkg::ROLE_WHITE) begin
            plan_nxt.src[4*p+1] = lhdr_pkg::SRC_FULL;
            plan_nxt.src[4*p+2] = lv;
            plan_nxt.wmask[4*p +: 4] = 4'hF;
            plan_nxt.fmask[4*p+2]    = 1'b1;
          end else if (ra == lhdr_pkg::ROLE_MINUS && rb == lhdr_pkg::ROLE_WHITE) begin
            plan_nxt.src[4*p]   = lhdr_pkg::SRC_FULL;
            plan_nxt.src[4*p+3] = lv;
            plan_nxt.wmask[4*p +: 4] = 4'hF;
            plan_nxt.fmask[4*p+3]    = 1'b1;
          end else begin
            plan_nxt.status = lhdr_pkg::ST_PAIR;
          end
        end
      end
      default: begin
        plan_nxt.status = lhdr_pkg::ST_MODE;
      end
    endcase
  end

  // refreshed every cycle; the user must change config only while the pipe is empty, the block does not enforce it
  always_ff @(posedge clk) begin
    plan_r <= plan_nxt;
  end

  assign plan = plan_r;

endmodule

@@ hw/rtl/lhdr_scale.sv @@
// ----------------------------------------------------------------------------
// lhdr_scale
// Three-stage level pipe: widen, multiply by brightness, divide by full scale.
// ----------------------------------------------------------------------------
module lhdr_scale #(
  parameter int DUTY_BITS = lhdr_pkg::DUTY_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic                                        in_light_on,
  input  logic [lhdr_pkg::LVL_BITS-1:0]               in_red,
  input  logic [lhdr_pkg::LVL_BITS-1:0]               in_green,
  input  logic [lhdr_pkg::LVL_BITS-1:0]               in_blue,
  input  logic [lhdr_pkg::LVL_BITS-1:0]               in_level_a,
  input  logic [lhdr_pkg::LVL_BITS-1:0]               in_level_b,
  output logic                                        dn_valid,
  input  logic                                        dn_ready,
  output logic [lhdr_pkg::LV_NUM-1:0][DUTY_BITS-1:0]  levels
);

  localparam int DB = DUTY_BITS;
  localparam int PW = 2 * DUTY_BITS;
  localparam int SH = DUTY_BITS - lhdr_pkg::LVL_BITS;
  localparam logic [DB-1:0] LOW_ONES = DB'((1 << SH) - 1);

  logic          v1_r, v2_r, v3_r;
  logic          en1, en2, en3;
  logic [DB-1:0] wide [5];
  logic [DB-1:0] col1_r [3];
  logic [DB-1:0] wa1_r, wb1_r;
  logic [PW-1:0] prod2_r [3];
  logic [DB-1:0] wa2_r, wb2_r;
  logic [DB-1:0] q3_nxt [3];
  logic [DB-1:0] q3_r [3];
  logic [DB-1:0] wa3_r, wb3_r;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign dn_valid = v3_r;

  always_comb begin
    wide[0] = (DB'(in_red)     << SH) | LOW_ONES;
    wide[1] = (DB'(in_green)   << SH) | LOW_ONES;
    wide[2] = (DB'(in_blue)    << SH) | LOW_ONES;
    wide[3] = (DB'(in_level_a) << SH) | LOW_ONES;
    wide[4] = (DB'(in_level_b) << SH) | LOW_ONES;
  end

  // x / (2^DB - 1) == (x + (x >> DB) + 1) >> DB for x <= (2^DB - 1)^2
  always_comb begin
    logic [PW:0] sum;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      sum      = {1'b0, prod2_r[i]} + (PW+1)'(prod2_r[i] >> DB) + (PW+1)'(1);
      q3_nxt[i] = sum[PW-1:DB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        col1_r[i] <= in_light_on ? wide[i] : '0;
      end
      wa1_r <= in_light_on ? wide[3] : '0;
      wb1_r <= in_light_on ? wide[4] : '0;
    end
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        prod2_r[i] <= PW'(col1_r[i]) * PW'(wa1_r);
      end
      wa2_r <= wa1_r;
      wb2_r <= wb1_r;
    end
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        q3_r[i] <= q3_nxt[i];
      end
      wa3_r <= wa2_r;
      wb3_r <= wb2_r;
    end
  end

  assign levels[lhdr_pkg::LV_RED]   = q3_r[0];
  assign levels[lhdr_pkg::LV_GREEN] = q3_r[1];
  assign levels[lhdr_pkg::LV_BLUE]  = q3_r[2];
  assign levels[lhdr_pkg::LV_A]     = wa3_r;
  assign levels[lhdr_pkg::LV_B]     = wb3_r;

endmodule

@@ hw/rtl/lhdr_route.sv @@
// ----------------------------------------------------------------------------
// lhdr_route
// Final stage: per-channel duty select, masks and status into the output reg.
// ----------------------------------------------------------------------------
`include "led_halfbridge_duty_router_macros.svh"

module lhdr_route #(
  parameter int DUTY_BITS = lhdr_pkg::DUTY_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          up_valid,
  output logic                                          up_ready,
  input  logic [lhdr_pkg::LV_NUM-1:0][DUTY_BITS-1:0]    levels,
  input  lhdr_pkg::plan_t                               plan,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [lhdr_pkg::NUM_CH-1:0][DUTY_BITS-1:0]    duty,
  output logic [lhdr_pkg::NUM_CH-1:0]                   write_mask,
  output logic [lhdr_pkg::NUM_CH-1:0]                   fade_mask,
  output logic [2:0]                                    status
);

  logic                                         out_valid_r;
  logic [lhdr_pkg::NUM_CH-1:0][DUTY_BITS-1:0]   duty_nxt;
  logic [lhdr_pkg::NUM_CH-1:0][DUTY_BITS-1:0]   duty_r;
  logic [lhdr_pkg::NUM_CH-1:0]                  wmask_r;
  logic [lhdr_pkg::NUM_CH-1:0]                  fmask_r;
  logic [2:0]                                   status_r;
  logic [lhdr_pkg::NUM_CH-1:0]                  duty_nz;

  assign up_ready = !out_valid_r || out_ready;

  always_comb begin
    for (int i = 0; i < lhdr_pkg::NUM_CH; i++) begin
      case (plan.src[i])
        lhdr_pkg::SRC_ZERO:  duty_nxt[i] = '0;
        lhdr_pkg::SRC_FULL:  duty_nxt[i] = '1;
        lhdr_pkg::SRC_RED:   duty_nxt[i] = levels[lhdr_pkg::LV_RED];
        lhdr_pkg::SRC_GREEN: duty_nxt[i] = levels[lhdr_pkg::LV_GREEN];
        lhdr_pkg::SRC_BLUE:  duty_nxt[i] = levels[lhdr_pkg::LV_BLUE];
        lhdr_pkg::SRC_LVA:   duty_nxt[i] = levels[lhdr_pkg::LV_A];
        lhdr_pkg::SRC_LVB:   duty_nxt[i] = levels[lhdr_pkg::LV_B];
        default:             duty_nxt[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      duty_r   <= duty_nxt;
      wmask_r  <= plan.wmask;
      fmask_r  <= plan.fmask;
      status_r <= plan.status;
    end
  end

  always_comb begin
    for (int i = 0; i < lhdr_pkg::NUM_CH; i++) begin
      duty_nz[i] = (duty_r[i] != '0);
    end
  end

  assign out_valid  = out_valid_r;
  assign duty       = duty_r;
  assign write_mask = wmask_r;
  assign fade_mask  = fmask_r;
  assign status     = status_r;

  `LHDR_ASSERT_IMPL(a_fade_in_write, out_valid_r, (fmask_r & ~wmask_r) == '0, "fade on unwritten channel")
  `LHDR_ASSERT_IMPL(a_unwritten_zero, out_valid_r, (duty_nz & ~wmask_r) == '0, "duty on unwritten channel")
  `LHDR_ASSERT_IMPL(a_cfg_err_empty, out_valid_r && (status_r == lhdr_pkg::ST_MODE || status_r == lhdr_pkg::ST_POLARITY || status_r == lhdr_pkg::ST_COLORS), wmask_r == '0, "masks set on config error")
  `LHDR_ASSERT_NEXT(a_load_valid, up_valid && up_ready, out_valid_r, "accepted item lost at output stage")

endmodule
